// File: src/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg: shared types and helpers for the circular tournament survivor block
// Widths of the beats rows and meet-table rows, the span-unit control group
// and the position-to-player wrap.
// ----------------------------------------------------------------------------
package cts_pkg;

	localparam int MAX_PLAYERS = 32;
	localparam int PLAYER_W    = 5;
	localparam int POS_W       = 6;
	localparam int ROW_W       = MAX_PLAYERS;
	localparam int TBL_W       = 2 * MAX_PLAYERS;
	localparam int TBL_DEPTH   = 2 * MAX_PLAYERS;

	typedef logic [ROW_W-1:0]    row_t;
	typedef logic [TBL_W-1:0]    tbl_t;
	typedef logic [POS_W-1:0]    pos_t;
	typedef logic [PLAYER_W-1:0] player_t;

	// control from the sequencer to the span unit
	typedef struct packed {
		logic cap_x;  // capture the row of the start player
		logic cap_w;  // build the combined winner mask
	} cts_span_ctl_t;

	// position on the unrolled circle to player index, pos < 2n
	function automatic player_t pos_mod(input pos_t pos, input pos_t n);
		pos_t d;
		d = (pos >= n) ? pos - n : pos;
		return d[PLAYER_W-1:0];
	endfunction

endpackage

// File: src/cts_ram.sv
// ----------------------------------------------------------------------------
// cts_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// File: src/cts_span_unit.sv
// ----------------------------------------------------------------------------
// cts_span_unit: shared evaluation unit for one span of the interval table
// Builds the mask of split positions whose player is beaten by either end,
// replicated over the unrolled circle, and checks it against both table rows.
// ----------------------------------------------------------------------------
module cts_span_unit import cts_pkg::*; (
	input  logic          clk,
	input  cts_span_ctl_t ctl,
	input  row_t          beats_rd,
	input  pos_t          n,
	input  tbl_t          row_start,
	input  tbl_t          col_end,
	output logic          hit
);

	row_t bx_q;
	tbl_t win_q;
	tbl_t n_mask;
	row_t comb_row;
	tbl_t comb_wide;

	// bits at or beyond n are dropped, then the row is copied to positions n..2n-1
	assign n_mask    = ~({TBL_W{1'b1}} << n);
	assign comb_row  = (bx_q | beats_rd) & n_mask[ROW_W-1:0];
	assign comb_wide = {{(TBL_W-ROW_W){1'b0}}, comb_row};

	always_ff @(posedge clk) begin
		if (ctl.cap_x) begin
			bx_q <= beats_rd;
		end
		if (ctl.cap_w) begin
			win_q <= comb_wide | (comb_wide << n);
		end
	end

	assign hit = |(row_start & col_end & win_q);

endmodule

// File: src/circular_tournament_survivor_dp.sv
// ----------------------------------------------------------------------------
// circular_tournament_survivor_dp: who can survive a circular knockout
// Loads the beats matrix row by row, runs the interval meet table over the
// circle unrolled to 2n positions and reports one survival flag per player.
//
//   channel  dir  handshake            fields
//   in       in   in_valid/in_ready    row_index, beats_row, last_row
//   out      out  out_valid/out_ready  player, can_survive, last_result
//   cfg      in   cfg_wr_en            cfg_wr_data (player_count)
//
// a row beat without last_row is written to the beats RAM and the sequencer stays idle
// a last row beat then clears and seeds the table rows of the unrolled circle, runs
//   each (span, start) pair through S_RD, S_RD2, S_EXP and S_EVAL on the shared span unit,
//   and steps each result through S_ORD, S_OLD and S_OUT, holding in S_OUT while out_ready is low
// in_ready is low from the last row beat until the final result is taken
// reset returns the sequencer to idle, player_count to 32
// ----------------------------------------------------------------------------
module circular_tournament_survivor_dp import cts_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [5:0]    cfg_wr_data,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [4:0]    row_index,
	input  logic [31:0]   beats_row,
	input  logic          last_row,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [4:0]    player,
	output logic          can_survive,
	output logic          last_result
);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_CLR  = 9'b000000010,
		S_RD   = 9'b000000100,
		S_RD2  = 9'b000001000,
		S_EXP  = 9'b000010000,
		S_EVAL = 9'b000100000,
		S_ORD  = 9'b001000000,
		S_OLD  = 9'b010000000,
		S_OUT  = 9'b100000000
	} cts_state_t;

	cts_state_t state_q;
	pos_t       player_count_q;
	pos_t       n_q;
	pos_t       pos_q;
	pos_t       start_q;
	pos_t       span_q;
	player_t    p_q;
	logic       out_valid_q;
	player_t    player_q;
	logic       can_survive_q;
	logic       last_result_q;

	logic [POS_W:0] two_n;
	logic [POS_W:0] end_w;
	logic [POS_W:0] end_nx;
	logic [POS_W:0] pos_nx;
	pos_t           end_pos;
	pos_t           n_eff;
	pos_t           surv_idx;
	logic           in_fire;
	logic           out_fire;
	logic           hit;

	logic    beats_we;
	player_t beats_raddr;
	row_t    beats_rd;
	logic    tbl_we;
	pos_t    row_waddr;
	pos_t    col_waddr;
	tbl_t    row_wdata;
	tbl_t    col_wdata;
	pos_t    row_raddr;
	tbl_t    row_rd;
	tbl_t    col_rd;
	cts_span_ctl_t span_ctl;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid_q && out_ready;
	assign two_n    = {n_q, 1'b0};
	assign end_w    = {1'b0, start_q} + {1'b0, span_q};
	assign end_pos  = end_w[POS_W-1:0];
	assign end_nx   = end_w + (POS_W+1)'(1);
	assign pos_nx   = {1'b0, pos_q} + (POS_W+1)'(1);
	assign surv_idx = {1'b0, p_q} + n_q;

	// out-of-range counts fold into 1..MAX_PLAYERS
	assign n_eff = (player_count_q == '0) ? pos_t'(1) :
		(player_count_q > pos_t'(MAX_PLAYERS)) ? pos_t'(MAX_PLAYERS) : player_count_q;

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign player      = player_q;
	assign can_survive = can_survive_q;
	assign last_result = last_result_q;

	// memories
	assign beats_we    = in_fire;
	assign beats_raddr = (state_q == S_RD) ? pos_mod(start_q, n_q) : pos_mod(end_pos, n_q);

	cts_ram #(.WIDTH(ROW_W), .DEPTH(MAX_PLAYERS)) u_beats_ram (
		.clk     (clk),
		.wr_en   (beats_we),
		.wr_addr (row_index),
		.wr_data (beats_row),
		.rd_addr (beats_raddr),
		.rd_data (beats_rd)
	);

	always_comb begin
		tbl_we    = 1'b0;
		row_waddr = start_q;
		col_waddr = end_pos;
		row_wdata = row_rd | (tbl_t'(1) << end_pos);
		col_wdata = col_rd | (tbl_t'(1) << start_q);
		if (state_q == S_CLR) begin
			tbl_we    = 1'b1;
			row_waddr = pos_q;
			col_waddr = pos_q;
			// clear and seed the adjacent pairs in the same sweep
			row_wdata = (pos_nx < two_n) ? (tbl_t'(1) << pos_nx) : '0;
			col_wdata = (pos_q != '0) ? (tbl_t'(1) << (pos_q - pos_t'(1))) : '0;
		end else if (state_q == S_EVAL) begin
			tbl_we = hit;
		end
	end

	assign row_raddr = (state_q == S_ORD) ? {1'b0, p_q} : start_q;

	cts_ram #(.WIDTH(TBL_W), .DEPTH(TBL_DEPTH)) u_row_ram (
		.clk     (clk),
		.wr_en   (tbl_we),
		.wr_addr (row_waddr),
		.wr_data (row_wdata),
		.rd_addr (row_raddr),
		.rd_data (row_rd)
	);

	cts_ram #(.WIDTH(TBL_W), .DEPTH(TBL_DEPTH)) u_col_ram (
		.clk     (clk),
		.wr_en   (tbl_we),
		.wr_addr (col_waddr),
		.wr_data (col_wdata),
		.rd_addr (end_pos),
		.rd_data (col_rd)
	);

	assign span_ctl.cap_x = (state_q == S_RD2);
	assign span_ctl.cap_w = (state_q == S_EXP);

	cts_span_unit u_span (
		.clk       (clk),
		.ctl       (span_ctl),
		.beats_rd  (beats_rd),
		.n         (n_q),
		.row_start (row_rd),
		.col_end   (col_rd),
		.hit       (hit)
	);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			player_count_q <= pos_t'(MAX_PLAYERS);
		end else if (cfg_wr_en) begin
			player_count_q <= cfg_wr_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			n_q         <= pos_t'(1);
			pos_q       <= '0;
			start_q     <= '0;
			span_q      <= '0;
			p_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire && last_row) begin
						n_q     <= n_eff;
						pos_q   <= '0;
						state_q <= S_CLR;
					end
				end
				S_CLR: begin
					pos_q <= pos_nx[POS_W-1:0];
					if (pos_nx == two_n) begin
						start_q <= '0;
						span_q  <= pos_t'(2);
						p_q     <= '0;
						state_q <= (n_q == pos_t'(1)) ? S_ORD : S_RD;
					end
				end
				S_RD:  state_q <= S_RD2;
				S_RD2: state_q <= S_EXP;
				S_EXP: state_q <= S_EVAL;
				S_EVAL: begin
					if (end_nx < two_n) begin
						start_q <= start_q + pos_t'(1);
						state_q <= S_RD;
					end else if (span_q == n_q) begin
						p_q     <= '0;
						state_q <= S_ORD;
					end else begin
						span_q  <= span_q + pos_t'(1);
						start_q <= '0;
						state_q <= S_RD;
					end
				end
				S_ORD: state_q <= S_OLD;
				S_OLD: begin
					out_valid_q <= 1'b1;
					state_q     <= S_OUT;
				end
				S_OUT: begin
					if (out_fire) begin
						out_valid_q <= 1'b0;
						if ({1'b0, p_q} == n_q - pos_t'(1)) begin
							state_q <= S_IDLE;
						end else begin
							p_q     <= p_q + player_t'(1);
							state_q <= S_ORD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (state_q == S_OLD) begin
			player_q      <= p_q;
			can_survive_q <= row_rd[surv_idx];
			last_result_q <= ({1'b0, p_q} == n_q - pos_t'(1));
		end
	end

	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid_q))
		else $error("input accepted while a result beat is pending");

	a_out_in_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (state_q == S_OUT))
		else $error("result beat shown outside the output state");

	a_span_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL) |-> (end_w < two_n))
		else $error("span end beyond the unrolled circle");

	a_player_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ({1'b0, player_q} < n_q))
		else $error("result for a player beyond the count");

	a_last_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && last_result_q) |=> in_ready)
		else $error("input not ready after the last result beat");

endmodule
